// File: rtl/core/joystick_servo_position_controller_macros.svh
// Assertion macros for the joystick servo position controller.
// No dependencies; included by the files that carry assertions.
`ifndef JOYSTICK_SERVO_POSITION_CONTROLLER_MACROS_SVH
`define JOYSTICK_SERVO_POSITION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, clocked on clk_i, off while rst_ni is low.
`define JSPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jspc assertion failed");
// Antecedent this cycle implies consequent in the next cycle.
`define JSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jspc assertion failed");
`else
`define JSPC_ASSERT(lbl, prop)
`define JSPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/jspc_pkg.sv
// Types and constants of the joystick servo position controller.
// No dependencies; used by the top level.
package jspc_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned AngleW    = 8;
  localparam int unsigned StepW     = 4;
  localparam int unsigned Axes      = 4;
  localparam int unsigned OutServos = 6;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [SampleW-1:0] Centre   = 10'd512;
  localparam logic [SampleW-1:0] DeadZone = 10'd20;
  localparam logic [SampleW-1:0] AdcMax   = 10'd1023;
  localparam logic [SampleW-1:0] ThrReset = 10'd20;
  localparam logic [AngleW-1:0]  AngleMax = 8'd180;
  localparam logic [AngleW-1:0]  AngleMid = 8'd90;
  localparam logic [StepW-1:0]   StepMin  = 4'd1;
  localparam logic [StepW-1:0]   StepMax  = 4'd10;
  localparam logic [Axes-1:0]    InvertReset = 4'b0010;

  // v*180/1023 as a multiply by a rounded-up reciprocal; exact for 10-bit v
  localparam int unsigned ScaleShift = 21;
  localparam int unsigned ScaleMulW  = 19;
  localparam logic [ScaleMulW-1:0] ScaleMul = ScaleMulW'(
      (int'(AngleMax) * (1 << ScaleShift) + int'(AdcMax) - 1) / int'(AdcMax));

  typedef enum logic [1:0] {
    ModeDirect = 2'd1,
    ModeIncr   = 2'd2,
    ModeHold   = 2'd3
  } mode_e;

  typedef enum logic {
    OpTick = 1'b0,
    OpSet  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 3'd0,
    CfgStep   = 3'd1,
    CfgThr1X  = 3'd2,
    CfgThr1Y  = 3'd3,
    CfgThr2X  = 3'd4,
    CfgThr2Y  = 3'd5,
    CfgInvert = 3'd6
  } cfg_idx_e;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [AngleW-1:0]  angle_t;

  typedef struct packed {
    logic              op;
    logic [SampleW-1:0] sample_stick1_x;
    logic [SampleW-1:0] sample_stick1_y;
    logic [SampleW-1:0] sample_stick2_x;
    logic [SampleW-1:0] sample_stick2_y;
    logic [ChanW-1:0]   set_channel;
    logic [AngleW-1:0]  set_angle;
  } in_req_t;

  typedef struct packed {
    logic [AngleW-1:0]    position_0;
    logic [AngleW-1:0]    position_1;
    logic [AngleW-1:0]    position_2;
    logic [AngleW-1:0]    position_3;
    logic [AngleW-1:0]    position_4;
    logic [AngleW-1:0]    position_5;
    logic [OutServos-1:0] updated_mask;
  } out_req_t;

endpackage

// File: rtl/core/joystick_servo_position_controller.sv
// channel | direction | handshake                  | payload
// in      | into      | in_valid_i / in_stall_o    | in_req_i  (jspc_pkg::in_req_t)
// out     | out of    | out_valid_o / out_stall_i  | out_req_o (jspc_pkg::out_req_t)
// cfg     | into      | cfg_we_i, no back-pressure | cfg_index_i, cfg_data_i
//
// One request per clock is sustained while the output is not stalled; each request goes
// through history read, running sum, mean multiply, scale multiply and state update.
// The history memory has one read and one write port; a tick that reads the row the
// previous tick is writing gets the data forwarded.
// Reset: rings read as 512 through per-row valid flags, so no clearing pass is needed.
// A stalled result holds the output register; the stall backs up stage by stage and
// bubbles are squeezed out, so in_stall_o only rises when every stage is full.
//
// Top level of the joystick servo position controller.
// Depends on jspc_pkg and the assertion macro header.
`include "joystick_servo_position_controller_macros.svh"

module joystick_servo_position_controller #(
  parameter int unsigned AVG_DEPTH   = 10,
  parameter int unsigned SERVO_COUNT = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  jspc_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output jspc_pkg::out_req_t               out_req_o,
  input  logic                             cfg_we_i,
  input  logic [jspc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [jspc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import jspc_pkg::*;

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int unsigned SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SumW  = $clog2(int'(AdcMax) * AVG_DEPTH + 1);
  localparam int unsigned RowW  = Axes * SampleW;
  // mean = (sum * MeanRecip) >> MulK, exact for every sum below 2**SumW
  localparam int unsigned MulK  = SumW + $clog2(AVG_DEPTH) + 1;
  localparam int unsigned RecW  = MulK + 1;
  localparam int unsigned ProdW = SumW + RecW;
  localparam longint unsigned MeanRecipL =
      ((64'd1 << MulK) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RecW-1:0]  MeanRecip = RecW'(MeanRecipL);
  localparam logic [SumW-1:0]  SumReset  = SumW'(int'(Centre) * AVG_DEPTH);
  localparam logic [SumW-1:0]  SumMax    = SumW'(int'(AdcMax) * AVG_DEPTH);
  localparam logic [SlotW-1:0] SlotLast  = SlotW'(AVG_DEPTH - 1);
  localparam int unsigned SclW = SampleW + ScaleMulW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_e             mode_q;
  logic [StepW-1:0]  step_q;
  sample_t           thr_q [Axes];
  logic [Axes-1:0]   inv_q;
  logic              mode_wr;
  logic [1:0]        thr_sel;

  assign mode_wr = cfg_we_i && (cfg_index_i == CfgMode) && (cfg_data_i[1:0] != 2'b00);
  assign thr_sel = 2'(cfg_index_i - CfgThr1X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDirect;
      step_q <= StepMin;
      for (int a = 0; a < Axes; a++) thr_q[a] <= ThrReset;
      inv_q  <= InvertReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        CfgMode: begin
          // mode 0 means nothing and is dropped
          if (mode_wr) mode_q <= mode_e'(cfg_data_i[1:0]);
        end
        CfgStep: begin
          if (cfg_data_i[StepW-1:0] >= StepMin && cfg_data_i[StepW-1:0] <= StepMax) begin
            step_q <= cfg_data_i[StepW-1:0];
          end
        end
        CfgThr1X, CfgThr1Y, CfgThr2X, CfgThr2Y: begin
          thr_q[thr_sel] <= cfg_data_i[SampleW-1:0];
        end
        CfgInvert: inv_q <= cfg_data_i[Axes-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: per-stage valids, ready ripples back from the output register
  // ---------------------------------------------------------------------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, out_vld_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy, out_rdy;
  logic in_acc, a_adv, d_adv;

  assign out_rdy = !out_vld_q || !out_stall_i;
  assign d_rdy   = !d_vld_q || out_rdy;
  assign c_rdy   = !c_vld_q || d_rdy;
  assign b_rdy   = !b_vld_q || c_rdy;
  assign a_rdy   = !a_vld_q || b_rdy;

  assign in_acc  = in_valid_i && a_rdy;
  assign a_adv   = a_vld_q && b_rdy;
  assign d_adv   = d_vld_q && out_rdy;

  assign in_stall_o  = !a_rdy;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (a_rdy)   a_vld_q   <= in_valid_i;
      if (b_rdy)   b_vld_q   <= a_vld_q;
      if (c_rdy)   c_vld_q   <= b_vld_q;
      if (d_rdy)   d_vld_q   <= c_vld_q;
      if (out_rdy) out_vld_q <= d_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample history memory: one row per slot, four axes side by side
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]      hist_mem [AVG_DEPTH];
  logic [RowW-1:0]      hist_rd_q;
  logic [AVG_DEPTH-1:0] row_vld_q;
  logic [SlotW-1:0]     slot_q;
  logic [SlotW-1:0]     a_slot_q;
  logic                 in_tick, a_wr;
  logic [RowW-1:0]      in_row, a_row;

  assign in_tick = (in_req_i.op == OpTick);
  assign in_row  = {in_req_i.sample_stick2_y, in_req_i.sample_stick2_x,
                    in_req_i.sample_stick1_y, in_req_i.sample_stick1_x};

  always_ff @(posedge clk_i) begin
    if (a_wr)   hist_mem[a_slot_q] <= a_row;
    if (in_acc) hist_rd_q <= hist_mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      slot_q    <= '0;
    end else begin
      if (a_wr) row_vld_q[a_slot_q] <= 1'b1;
      if (in_acc && in_tick) slot_q <= (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: history row arrives, running sums are updated
  // ---------------------------------------------------------------------------
  logic             a_op_q;
  logic [RowW-1:0]  a_row_q;
  logic [ChanW-1:0] a_ch_q;
  angle_t           a_ang_q;
  logic             a_rvld_q;
  logic             a_fwd_q;
  logic [RowW-1:0]  a_fwd_row_q;
  logic [SumW-1:0]  sum_q   [Axes];
  logic [SumW-1:0]  sum_new [Axes];
  sample_t          old_smp [Axes];

  assign a_row = a_row_q;
  assign a_wr  = a_adv && (a_op_q == OpTick);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_op_q      <= in_req_i.op;
      a_slot_q    <= slot_q;
      a_row_q     <= in_row;
      a_ch_q      <= in_req_i.set_channel;
      a_ang_q     <= in_req_i.set_angle;
      a_rvld_q    <= row_vld_q[slot_q];
      a_fwd_row_q <= a_row_q;
    end
  end

  // row being written as the new tick reads it: take the write data instead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_fwd_q <= 1'b0;
    end else if (in_acc) begin
      a_fwd_q <= a_wr && (a_slot_q == slot_q);
    end else if (a_adv) begin
      a_fwd_q <= 1'b0;
    end
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      if (a_fwd_q) begin
        old_smp[a] = a_fwd_row_q[a*SampleW +: SampleW];
      end else if (a_rvld_q) begin
        old_smp[a] = hist_rd_q[a*SampleW +: SampleW];
      end else begin
        old_smp[a] = Centre;
      end
      sum_new[a] = SumW'(({1'b0, sum_q[a]} + (SumW+1)'(a_row_q[a*SampleW +: SampleW]))
                         - (SumW+1)'(old_smp[a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) sum_q[a] <= SumReset;
    end else if (a_wr) begin
      for (int a = 0; a < Axes; a++) sum_q[a] <= sum_new[a];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: mean by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic             b_op_q;
  logic [ChanW-1:0] b_ch_q;
  angle_t           b_ang_q;
  logic [SumW-1:0]  b_sum_q  [Axes];
  logic [ProdW-1:0] mean_prod [Axes];

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_op_q  <= a_op_q;
      b_ch_q  <= a_ch_q;
      b_ang_q <= a_ang_q;
      for (int a = 0; a < Axes; a++) b_sum_q[a] <= sum_new[a];
    end
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      mean_prod[a] = ProdW'(b_sum_q[a]) * ProdW'(MeanRecip);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: optional inversion, then scale to degrees
  // ---------------------------------------------------------------------------
  logic             c_op_q;
  logic [ChanW-1:0] c_ch_q;
  angle_t           c_ang_q;
  sample_t          c_mean_q [Axes];
  sample_t          c_v      [Axes];
  logic [SclW-1:0]  scl_prod [Axes];

  always_ff @(posedge clk_i) begin
    if (b_vld_q && c_rdy) begin
      c_op_q  <= b_op_q;
      c_ch_q  <= b_ch_q;
      c_ang_q <= b_ang_q;
      for (int a = 0; a < Axes; a++) c_mean_q[a] <= mean_prod[a][MulK +: SampleW];
    end
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      c_v[a]      = inv_q[a] ? (AdcMax - c_mean_q[a]) : c_mean_q[a];
      scl_prod[a] = SclW'(c_v[a]) * SclW'(ScaleMul);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: per-axis decisions against the servo state, committed on exit
  // ---------------------------------------------------------------------------
  logic             d_op_q;
  logic [ChanW-1:0] d_ch_q;
  angle_t           d_ang_q;
  sample_t          d_mean_q [Axes];
  sample_t          d_v_q    [Axes];
  angle_t           d_scl_q  [Axes];

  always_ff @(posedge clk_i) begin
    if (c_vld_q && d_rdy) begin
      d_op_q  <= c_op_q;
      d_ch_q  <= c_ch_q;
      d_ang_q <= c_ang_q;
      for (int a = 0; a < Axes; a++) begin
        d_mean_q[a] <= c_mean_q[a];
        d_v_q[a]    <= c_v[a];
        d_scl_q[a]  <= scl_prod[a][ScaleShift +: AngleW];
      end
    end
  end

  sample_t              last_dm_q  [Axes];
  sample_t              last_inc_q [Axes];
  angle_t               pos_q      [SERVO_COUNT];
  sample_t              last_dm_d  [Axes];
  sample_t              last_inc_d [Axes];
  angle_t               pos_d      [SERVO_COUNT];
  angle_t               pos_ext    [OutServos];
  logic [OutServos-1:0] mask_d;
  out_req_t             out_d;
  out_req_t             out_q;

  // per-axis comparisons, kept apart from the update mux
  sample_t dm_diff  [Axes];
  sample_t inc_off  [Axes];
  logic    inc_hi   [Axes];
  logic    inc_lo   [Axes];
  angle_t  pos_up   [Axes];
  angle_t  pos_dn   [Axes];
  logic    set_ok;

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      dm_diff[a] = (d_mean_q[a] >= last_dm_q[a]) ? (d_mean_q[a] - last_dm_q[a])
                                                 : (last_dm_q[a] - d_mean_q[a]);
      inc_off[a] = (d_v_q[a] >= Centre) ? (d_v_q[a] - Centre) : (Centre - d_v_q[a]);
      inc_hi[a]  = {1'b0, d_v_q[a]} > ({1'b0, Centre} + {1'b0, thr_q[a]});
      inc_lo[a]  = ({1'b0, d_v_q[a]} + {1'b0, thr_q[a]}) < {1'b0, Centre};
      pos_up[a]  = pos_q[a] + AngleW'(step_q);
      pos_dn[a]  = pos_q[a] - AngleW'(step_q);
    end
    set_ok = (32'(d_ch_q) < SERVO_COUNT) && (d_ang_q <= AngleMax);
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      last_dm_d[a]  = last_dm_q[a];
      last_inc_d[a] = last_inc_q[a];
    end
    for (int j = 0; j < SERVO_COUNT; j++) pos_d[j] = pos_q[j];
    mask_d = '0;

    if (d_op_q == OpTick) begin
      case (mode_q)
        ModeDirect: begin
          for (int a = 0; a < Axes; a++) begin
            if (dm_diff[a] >= thr_q[a]) begin
              pos_d[a]     = d_scl_q[a];
              last_dm_d[a] = d_mean_q[a];
              mask_d[a]    = 1'b1;
            end
          end
        end
        ModeIncr: begin
          for (int a = 0; a < Axes; a++) begin
            if (inc_off[a] > DeadZone) begin
              last_inc_d[a] = d_v_q[a];
              // crossing the centre only re-arms, no step
              if (!((last_inc_q[a] <= Centre && inc_hi[a]) ||
                    (last_inc_q[a] >= Centre && inc_lo[a]))) begin
                if (inc_hi[a]) begin
                  pos_d[a]  = (pos_up[a] > AngleMax) ? AngleMax : pos_up[a];
                  mask_d[a] = 1'b1;
                end else if (inc_lo[a]) begin
                  pos_d[a]  = (pos_q[a] < AngleW'(step_q)) ? '0 : pos_dn[a];
                  mask_d[a] = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end else begin
      for (int j = 0; j < SERVO_COUNT; j++) begin
        if (set_ok && d_ch_q == ChanW'(j)) pos_d[j] = d_ang_q;
      end
      for (int j = 0; j < OutServos; j++) begin
        if (set_ok && d_ch_q == ChanW'(j)) mask_d[j] = 1'b1;
      end
    end
  end

  for (genvar j = 0; j < OutServos; j++) begin : g_pos_ext
    if (j < SERVO_COUNT) begin : g_live
      assign pos_ext[j] = pos_d[j];
    end else begin : g_absent
      assign pos_ext[j] = '0;
    end
  end

  always_comb begin
    out_d.position_0   = pos_ext[0];
    out_d.position_1   = pos_ext[1];
    out_d.position_2   = pos_ext[2];
    out_d.position_3   = pos_ext[3];
    out_d.position_4   = pos_ext[4];
    out_d.position_5   = pos_ext[5];
    out_d.updated_mask = mask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Axes; a++) begin
        last_dm_q[a]  <= Centre;
        last_inc_q[a] <= Centre;
      end
      for (int j = 0; j < SERVO_COUNT; j++) pos_q[j] <= AngleMid;
    end else if (mode_wr) begin
      // mode change recenters every servo
      for (int j = 0; j < SERVO_COUNT; j++) pos_q[j] <= AngleMid;
    end else if (d_adv) begin
      for (int a = 0; a < Axes; a++) begin
        last_dm_q[a]  <= last_dm_d[a];
        last_inc_q[a] <= last_inc_d[a];
      end
      for (int j = 0; j < SERVO_COUNT; j++) pos_q[j] <= pos_d[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_adv) out_q <= out_d;
  end

  assign out_req_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `JSPC_ASSERT(a_fwd_has_req, a_fwd_q |-> a_vld_q)
  `JSPC_ASSERT_NEXT(a_result_lands, d_vld_q && out_rdy, out_vld_q)
  `JSPC_ASSERT(a_pos_bound, out_vld_q |-> (out_q.position_0 <= AngleMax &&
      out_q.position_1 <= AngleMax && out_q.position_2 <= AngleMax &&
      out_q.position_3 <= AngleMax && out_q.position_4 <= AngleMax &&
      out_q.position_5 <= AngleMax))
  for (genvar g = 0; g < Axes; g++) begin : g_sum_chk
    `JSPC_ASSERT(a_sum_bound, sum_q[g] <= SumMax)
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the joystick servo position controller.
// Holds its own model of the servo positions; needs jspc_pkg and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jspc_pkg::*;

  localparam int AvgDepth      = 10;
  localparam int ClkPeriod     = 4;
  localparam int IdlePct       = 11;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 100;
  localparam int DrainCycles   = 20;
  localparam int CycleLimit    = 100000;  // far above the slowest legal run
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // integer copies of the package constants, so the math below stays signed
  localparam int CentreLvl = Centre;
  localparam int DeadBand  = DeadZone;
  localparam int FullScale = AdcMax;
  localparam int MaxAngle  = AngleMax;
  localparam int MidAngle  = AngleMid;

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  // one line of the directed table: a request or a register write
  typedef struct packed {
    row_kind_e            kind;
    in_req_t              req;
    logic                 typed;   // want holds a hand-written result
    out_req_t             want;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
  } directed_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_req_t             in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_req_t            out_req_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // no random idling on either side while this is set
  logic calm = 1'b0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // model state: rings of samples, per-axis memories, servo angles, registers
  sample_t ring_hist [Axes][AvgDepth];
  int      hist_slot;
  int      last_mean [Axes];
  int      last_level [Axes];
  int      servo_pos [OutServos];
  mode_e   cur_mode;
  int      step_deg;
  int      axis_thr [Axes];
  logic [Axes-1:0] invert_bits;

  out_req_t      pending_positions [$];
  directed_row_t directed_rows [$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  joystick_servo_position_controller #(
    .AVG_DEPTH  (AvgDepth),
    .SERVO_COUNT(OutServos)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Works out the servo angles and update mask that one accepted request leaves.
  function automatic out_req_t predict_positions(in_req_t r);
    out_req_t           o;
    logic [OutServos-1:0] hit;
    sample_t            samp [Axes];
    int                 sum, m, v, off, diff, t, pos;
    hit = '0;
    if (r.op == OpTick) begin
      samp = '{r.sample_stick1_x, r.sample_stick1_y, r.sample_stick2_x, r.sample_stick2_y};
      for (int a = 0; a < Axes; a++) ring_hist[a][hist_slot] = samp[a];
      for (int a = 0; a < Axes; a++) begin
        sum = 0;
        for (int i = 0; i < AvgDepth; i++) sum += ring_hist[a][i];
        m = sum / AvgDepth;
        v = invert_bits[a] ? FullScale - m : m;
        t = axis_thr[a];
        if (cur_mode == ModeDirect) begin
          diff = m - last_mean[a];
          if (diff < 0) diff = -diff;
          if (diff >= t) begin
            servo_pos[a] = v * MaxAngle / FullScale;
            last_mean[a] = m;
            hit[a] = 1'b1;
          end
        end else if (cur_mode == ModeIncr) begin
          off = v - CentreLvl;
          if (off < 0) off = -off;
          if (off > DeadBand) begin
            // a swing across the centre only re-arms the axis
            if ((last_level[a] <= CentreLvl && v > CentreLvl + t) ||
                (last_level[a] >= CentreLvl && v < CentreLvl - t)) begin
              last_level[a] = v;
            end else begin
              pos = servo_pos[a];
              if (v > CentreLvl + t) begin
                pos += step_deg;
                if (pos > MaxAngle) pos = MaxAngle;
                hit[a] = 1'b1;
              end else if (v < CentreLvl - t) begin
                pos -= step_deg;
                if (pos < 0) pos = 0;
                hit[a] = 1'b1;
              end
              servo_pos[a] = pos;
              last_level[a] = v;
            end
          end
        end
      end
      hist_slot = (hist_slot + 1 >= AvgDepth) ? 0 : hist_slot + 1;
    end else if (r.set_channel < OutServos && r.set_angle <= AngleMax) begin
      servo_pos[r.set_channel] = r.set_angle;
      hit[r.set_channel] = 1'b1;
    end
    o = '0;
    // position_0 sits at the top of the struct, the mask at the bottom
    for (int j = 0; j < OutServos; j++)
      o[OutServos + AngleW * (OutServos - 1 - j) +: AngleW] = angle_t'(servo_pos[j]);
    o.updated_mask = hit;
    return o;
  endfunction

  function automatic in_req_t tick_req(sample_t s1x, sample_t s1y, sample_t s2x, sample_t s2y);
    in_req_t r;
    r = '0;
    r.op = OpTick;
    r.sample_stick1_x = s1x;
    r.sample_stick1_y = s1y;
    r.sample_stick2_x = s2x;
    r.sample_stick2_y = s2y;
    return r;
  endfunction

  // the sample fields of a direct set carry junk that must be ignored
  function automatic in_req_t direct_set(logic [ChanW-1:0] ch, angle_t ang, sample_t junk);
    in_req_t r;
    r = tick_req(junk, junk, junk, junk);
    r.op = OpSet;
    r.set_channel = ch;
    r.set_angle = ang;
    return r;
  endfunction

  function automatic out_req_t angles(int a0, int a1, int a2, int a3, int a4, int a5,
                                      logic [OutServos-1:0] mask);
    out_req_t o;
    o.position_0 = angle_t'(a0);
    o.position_1 = angle_t'(a1);
    o.position_2 = angle_t'(a2);
    o.position_3 = angle_t'(a3);
    o.position_4 = angle_t'(a4);
    o.position_5 = angle_t'(a5);
    o.updated_mask = mask;
    return o;
  endfunction

  function automatic directed_row_t req_row(in_req_t r, logic typed, out_req_t want);
    directed_row_t row;
    row = '0;
    row.kind = RowReq;
    row.req = r;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic directed_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    directed_row_t row;
    row = '0;
    row.kind = RowCfg;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // Register writes go in only with the pipeline empty; the model follows along.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMode: begin
        // mode 0 is dropped and does not recentre
        if (data[1:0] != 2'd0) begin
          cur_mode = mode_e'(data[1:0]);
          for (int j = 0; j < OutServos; j++) servo_pos[j] = MidAngle;
        end
      end
      CfgStep: begin
        if (data[StepW-1:0] >= StepMin && data[StepW-1:0] <= StepMax)
          step_deg = data[StepW-1:0];
      end
      CfgThr1X, CfgThr1Y, CfgThr2X, CfgThr2Y: axis_thr[int'(idx) - int'(CfgThr1X)] = data;
      CfgInvert: invert_bits = data[Axes-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one request, holds it through any stall, and queues what it should produce.
  task automatic send_request(in_req_t r, logic typed, out_req_t want);
    out_req_t predicted;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_positions(r);
    pending_positions.push_back(typed ? want : predicted);
  endtask

  task automatic check_positions(out_req_t got);
    out_req_t want;
    angle_t   g, w;
    if (pending_positions.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, got %p", $time, got);
      mismatches++;
      return;
    end
    want = pending_positions.pop_front();
    for (int j = 0; j < OutServos; j++) begin
      g = got[OutServos + AngleW * (OutServos - 1 - j) +: AngleW];
      w = want[OutServos + AngleW * (OutServos - 1 - j) +: AngleW];
      if (g !== w) begin
        $display("%0t: position_%0d expected %0d, got %0d", $time, j, w, g);
        mismatches++;
      end
    end
    if (got.updated_mask !== want.updated_mask) begin
      $display("%0t: updated_mask expected %b, got %b", $time, want.updated_mask,
               got.updated_mask);
      mismatches++;
    end
  endtask

  // Result side: check what left at this edge, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_positions(out_req_o);
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_req_t         r;
    sample_t         s [Axes];
    int              stick_level [Axes];
    int              lvl;
    logic [CfgDataW-1:0] thr_val;

    // model reset: rings and memories at mid-scale, servos centred
    for (int a = 0; a < Axes; a++) begin
      for (int i = 0; i < AvgDepth; i++) ring_hist[a][i] = Centre;
      last_mean[a]   = CentreLvl;
      last_level[a]  = CentreLvl;
      axis_thr[a]    = ThrReset;
      stick_level[a] = CentreLvl;
    end
    for (int j = 0; j < OutServos; j++) servo_pos[j] = MidAngle;
    hist_slot   = 0;
    cur_mode    = ModeDirect;
    step_deg    = StepMin;
    invert_bits = InvertReset;

    // Directed table. Rows with a typed result follow straight from reset
    // values and the direct-set rules; the rest go through the model.
    // centred samples after reset: nothing moves
    directed_rows.push_back(req_row(tick_req(512, 512, 512, 512), 1'b1,
                                    angles(90, 90, 90, 90, 90, 90, 6'b000000)));
    // direct sets at both angle extremes and the two channel extremes
    directed_rows.push_back(req_row(direct_set(0, 0, 0), 1'b1,
                                    angles(0, 90, 90, 90, 90, 90, 6'b000001)));
    directed_rows.push_back(req_row(direct_set(5, 180, 0), 1'b1,
                                    angles(0, 90, 90, 90, 90, 180, 6'b100000)));
    // channel past the last servo, and angle past 180: dropped
    directed_rows.push_back(req_row(direct_set(6, 10, 0), 1'b1,
                                    angles(0, 90, 90, 90, 90, 180, 6'b000000)));
    directed_rows.push_back(req_row(direct_set(7, 255, 1023), 1'b1,
                                    angles(0, 90, 90, 90, 90, 180, 6'b000000)));
    directed_rows.push_back(req_row(direct_set(2, 181, 0), 1'b1,
                                    angles(0, 90, 90, 90, 90, 180, 6'b000000)));
    // full-scale junk in the sample fields must not reach the rings
    directed_rows.push_back(req_row(direct_set(3, 180, 1023), 1'b1,
                                    angles(0, 90, 90, 180, 90, 180, 6'b001000)));
    // sample extremes in direct mode, inverted axis included
    directed_rows.push_back(req_row(tick_req(1023, 0, 1023, 0), 1'b0, '0));
    directed_rows.push_back(req_row(tick_req(1023, 0, 1023, 0), 1'b0, '0));
    directed_rows.push_back(req_row(tick_req(0, 1023, 0, 1023), 1'b0, '0));
    // mode 0 is rejected and must not recentre
    directed_rows.push_back(cfg_row(CfgMode, 10'd0));
    directed_rows.push_back(req_row(direct_set(1, 7, 0), 1'b0, '0));
    // incremental mode; out-of-range step sizes and the unused index do nothing
    directed_rows.push_back(cfg_row(CfgMode, CfgDataW'(ModeIncr)));
    directed_rows.push_back(cfg_row(CfgStep, 10'd10));
    directed_rows.push_back(cfg_row(CfgStep, 10'd0));
    directed_rows.push_back(cfg_row(CfgStep, 10'd11));
    directed_rows.push_back(cfg_row(CfgUnused, 10'd1023));
    // first push across centre only re-arms, later ones step
    for (int k = 0; k < 4; k++)
      directed_rows.push_back(req_row(tick_req(1023, 1023, 1023, 1023), 1'b0, '0));
    directed_rows.push_back(req_row(tick_req(0, 0, 0, 0), 1'b0, '0));
    directed_rows.push_back(cfg_row(CfgThr1X, 10'd0));
    directed_rows.push_back(cfg_row(CfgThr2Y, 10'd1023));
    directed_rows.push_back(req_row(tick_req(0, 0, 0, 0), 1'b0, '0));
    // hold mode: rings fill, servos stay
    directed_rows.push_back(cfg_row(CfgMode, CfgDataW'(ModeHold)));
    directed_rows.push_back(req_row(tick_req(1023, 0, 1023, 0), 1'b0, '0));
    directed_rows.push_back(cfg_row(CfgMode, CfgDataW'(ModeDirect)));
    directed_rows.push_back(cfg_row(CfgInvert, 10'hF));
    directed_rows.push_back(req_row(tick_req(0, 1023, 512, 1), 1'b0, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCfg) begin
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: each one reprograms every register, then plays stick
    // motions -- levels that hold for a while with jitter -- mixed with
    // direct sets and the odd wild sample.
    for (int p = 0; p < NumPhases; p++) begin
      calm = (p == 4);
      if ($urandom_range(0, 3) == 0) write_register(CfgMode, 10'd0);
      write_register(CfgStep, (p == 0) ? 10'd1 : (p == 1) ? 10'd10 :
                              CfgDataW'($urandom_range(0, 15)));
      for (int a = 0; a < Axes; a++) begin
        lvl = $urandom_range(0, 9);
        thr_val = (lvl == 0) ? 10'd0 : (lvl == 1) ? 10'd1023 :
                  CfgDataW'($urandom_range(1, 120));
        if (p == 0) thr_val = 10'd0;
        if (p == 1 && a == 0) thr_val = 10'd1023;
        write_register(CfgIdxW'(int'(CfgThr1X) + a), thr_val);
      end
      write_register(CfgInvert, (p == 0) ? 10'h0 : (p == 1) ? 10'hF :
                                CfgDataW'($urandom_range(0, 15)));
      case (p % 4)
        0, 2:    write_register(CfgMode, CfgDataW'(ModeIncr));
        1:       write_register(CfgMode, CfgDataW'(ModeDirect));
        default: write_register(CfgMode, CfgDataW'(ModeHold));
      endcase

      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          r = direct_set(ChanW'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) :
                                                              $urandom_range(0, 5)),
                         AngleW'(($urandom_range(0, 9) == 0) ? $urandom_range(181, 255) :
                                                               $urandom_range(0, 180)),
                         sample_t'($urandom));
        end else begin
          for (int a = 0; a < Axes; a++) begin
            if ($urandom_range(0, 9) == 0) begin
              case ($urandom_range(0, 3))
                0:       stick_level[a] = 0;
                1:       stick_level[a] = FullScale;
                2:       stick_level[a] = CentreLvl;
                default: stick_level[a] = $urandom_range(0, FullScale);
              endcase
            end
            lvl = stick_level[a] + int'($urandom_range(0, 30)) - 15;
            if ($urandom_range(0, 19) == 0) lvl = $urandom_range(0, FullScale);
            if (lvl < 0) lvl = 0;
            if (lvl > FullScale) lvl = FullScale;
            s[a] = sample_t'(lvl);
          end
          r = tick_req(s[0], s[1], s[2], s[3]);
          r.set_channel = ChanW'($urandom);
          r.set_angle = AngleW'($urandom);
        end
        send_request(r, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    // let any stray result show up before closing
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/jspc_pkg.sv
rtl/core/joystick_servo_position_controller.sv
dv/testbench.sv
